@@ sv/point_rotate_about_center_top_macros.svh @@
// Assertion macros for the point rotation block.
// Included by the top level; holds nothing but macro definitions.
`ifndef POINT_ROTATE_ABOUT_CENTER_TOP_MACROS_SVH
`define POINT_ROTATE_ABOUT_CENTER_TOP_MACROS_SVH

// Check that a condition implies another in the same cycle
`define PRAC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies another in the following cycle
`define PRAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/prac_pkg.sv @@
// Shared constants and the sine table generator for the point rotation block.
// No dependencies; imported by prac_trig and point_rotate_about_center_top.
package prac_pkg;

   // Configuration register widths
   localparam int ANGLE_W  = 10;
   localparam int CENTER_W = 12;

   // Configuration register indexes (word address bits)
   localparam logic [1:0] REG_ANGLE    = 2'd0;
   localparam logic [1:0] REG_CENTER_X = 2'd1;
   localparam logic [1:0] REG_CENTER_Y = 2'd2;

   // Degrees in one quadrant, and in a full turn
   localparam int QUARTER = 90;
   localparam int FULL_TURN = 360;

   // Pi with 30 fraction bits
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // Sine of k degrees (k in 0..90) with 30 fraction bits, by a Taylor series
   // to the x^17 term with a truncating multiply at every step.
   function automatic logic [63:0] sin_q30(input int unsigned k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      longint s;
      x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
      x2   = (x * x) >> 30;
      term = x;
      s    = longint'(x);
      term = ((term * x2) >> 30) / 64'd6;   s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd20;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd42;  s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd72;  s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd110; s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd156; s = s + longint'(term);
      term = ((term * x2) >> 30) / 64'd210; s = s - longint'(term);
      term = ((term * x2) >> 30) / 64'd272; s = s + longint'(term);
      if (s < 0) begin
         s = 0;
      end
      return 64'(s);
   endfunction

endpackage

@@ sv/point_rotate_about_center_top.sv @@
// Point rotation about a center: rotates each streamed point by the programmed
// whole-degree angle about the programmed center, rounding to nearest and
// saturating the result. One point is accepted every clock cycle unless every
// stage is full and the result side holds back. A point passes five registers:
// input register, center offset, multiply, sum and round, recenter and saturate.
// Back-pressure on the result side stalls only the stages that are full. The
// coefficients follow an angle write through the angle register and then the
// registered table lookup in prac_trig.
// Top level; depends on prac_pkg, prac_trig and the assertion macro header.
`include "point_rotate_about_center_top_macros.svh"

module point_rotate_about_center_top
   import prac_pkg::*;
#(
   parameter int COORD_WIDTH    = 16,
   parameter int FRAC_BITS      = 4,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   // Input points
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: point_x, point_y (from bit 0 up), zero padded to whole bytes
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // Rotated points
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: rot_x, rot_y (from bit 0 up), zero padded to whole bytes
   output logic [((2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // Configuration registers
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int CW     = COORD_WIDTH;
   localparam int T      = TRIG_FRAC_BITS;
   localparam int DATA_W = ((2 * CW + 7) / 8) * 8;
   localparam int CX_W   = CENTER_W + FRAC_BITS;
   localparam int D_W    = ((CW > CX_W) ? CW : CX_W) + 1;
   localparam int TRIG_W = T + 2;
   localparam int P_W    = D_W + TRIG_W;
   localparam int S_W    = P_W + 1;
   localparam int R_W    = S_W - T;
   localparam int F_W    = R_W + 1;

   localparam int NSTG   = 5;
   localparam int ST_IN  = 0;
   localparam int ST_OFS = 1;
   localparam int ST_MUL = 2;
   localparam int ST_RND = 3;
   localparam int ST_OUT = 4;

   localparam logic signed [S_W-1:0] HALF   = S_W'(longint'(1) <<< (T - 1));
   localparam logic signed [F_W-1:0] SAT_HI = F_W'((longint'(1) <<< (CW - 1)) - 1);
   localparam logic signed [F_W-1:0] SAT_LO = -SAT_HI - F_W'(1);
   localparam logic signed [TRIG_W-1:0] TRIG_HALF = TRIG_W'(longint'(1) <<< (T - 1));

   // Configuration registers
   logic signed [ANGLE_W-1:0]  angle_ff;
   logic signed [CENTER_W-1:0] center_x_ff;
   logic signed [CENTER_W-1:0] center_y_ff;
   logic                       csr_wr;

   // Pipeline control
   logic [NSTG-1:0] vld_ff;
   logic [NSTG-1:0] vld_in;
   logic [NSTG:0]   rdy;

   // Coefficients and scaled center
   logic signed [TRIG_W-1:0] sin_v;
   logic signed [TRIG_W-1:0] cos_v;
   logic signed [CX_W-1:0]   cx_scl;
   logic signed [CX_W-1:0]   cy_scl;

   // Stage payloads
   logic signed [CW-1:0]  px_ff;
   logic signed [CW-1:0]  py_ff;
   logic signed [D_W-1:0] dx_in;
   logic signed [D_W-1:0] dy_in;
   logic signed [D_W-1:0] dx_ff;
   logic signed [D_W-1:0] dy_ff;
   logic signed [P_W-1:0] dxc_in;
   logic signed [P_W-1:0] dys_in;
   logic signed [P_W-1:0] dxs_in;
   logic signed [P_W-1:0] dyc_in;
   logic signed [P_W-1:0] dxc_ff;
   logic signed [P_W-1:0] dys_ff;
   logic signed [P_W-1:0] dxs_ff;
   logic signed [P_W-1:0] dyc_ff;
   logic signed [S_W-1:0] sum_x;
   logic signed [S_W-1:0] sum_y;
   logic signed [R_W-1:0] rnd_x_in;
   logic signed [R_W-1:0] rnd_y_in;
   logic signed [R_W-1:0] rnd_x_ff;
   logic signed [R_W-1:0] rnd_y_ff;
   logic signed [F_W-1:0] fin_x;
   logic signed [F_W-1:0] fin_y;
   logic signed [CW-1:0]  rot_x_in;
   logic signed [CW-1:0]  rot_y_in;
   logic signed [CW-1:0]  rot_x_ff;
   logic signed [CW-1:0]  rot_y_ff;

   // Register write and readback
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff    <= '0;
         center_x_ff <= '0;
         center_y_ff <= '0;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_ANGLE:    angle_ff    <= csr_pwdata[ANGLE_W-1:0];
            REG_CENTER_X: center_x_ff <= csr_pwdata[CENTER_W-1:0];
            REG_CENTER_Y: center_y_ff <= csr_pwdata[CENTER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_ANGLE:    csr_prdata = 32'({angle_ff});
         REG_CENTER_X: csr_prdata = 32'({center_x_ff});
         REG_CENTER_Y: csr_prdata = 32'({center_y_ff});
         default:      csr_prdata = '0;
      endcase
   end

   // Cosine and sine for the programmed angle
   prac_trig #(
      .TRIG_FRAC_BITS(T)
   ) u_trig (
      .clock    (clock),
      .reset    (reset),
      .angle_deg(angle_ff),
      .sin_val  (sin_v),
      .cos_val  (cos_v)
   );

   assign cx_scl = CX_W'(center_x_ff) <<< FRAC_BITS;
   assign cy_scl = CX_W'(center_y_ff) <<< FRAC_BITS;

   // Ready ripples back from the output; a stage loads when empty or draining
   always_comb begin
      rdy[NSTG] = rsp_tready;
      for (int i = NSTG - 1; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
      vld_in[0] = rdy[0] ? req_tvalid : vld_ff[0];
      for (int i = 1; i < NSTG; i++) begin
         vld_in[i] = rdy[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = rdy[ST_IN];

   // Offset from the center
   assign dx_in = D_W'(px_ff) - D_W'(cx_scl);
   assign dy_in = D_W'(py_ff) - D_W'(cy_scl);

   // Four products
   assign dxc_in = P_W'(dx_ff) * P_W'(cos_v);
   assign dys_in = P_W'(dy_ff) * P_W'(sin_v);
   assign dxs_in = P_W'(dx_ff) * P_W'(sin_v);
   assign dyc_in = P_W'(dy_ff) * P_W'(cos_v);

   // Sum and round half up
   assign sum_x    = S_W'(dxc_ff) - S_W'(dys_ff) + HALF;
   assign sum_y    = S_W'(dxs_ff) + S_W'(dyc_ff) + HALF;
   assign rnd_x_in = R_W'(sum_x >>> T);
   assign rnd_y_in = R_W'(sum_y >>> T);

   // Add the center back and saturate
   always_comb begin
      fin_x = F_W'(rnd_x_ff) + F_W'(cx_scl);
      fin_y = F_W'(rnd_y_ff) + F_W'(cy_scl);
      priority if (fin_x > SAT_HI) begin
         rot_x_in = CW'(SAT_HI);
      end else if (fin_x < SAT_LO) begin
         rot_x_in = CW'(SAT_LO);
      end else begin
         rot_x_in = CW'(fin_x);
      end
      priority if (fin_y > SAT_HI) begin
         rot_y_in = CW'(SAT_HI);
      end else if (fin_y < SAT_LO) begin
         rot_y_in = CW'(SAT_LO);
      end else begin
         rot_y_in = CW'(fin_y);
      end
   end

   // Advance payload registers
   always_ff @(posedge clock) begin
      if (rdy[ST_IN]) begin
         px_ff <= req_tdata[CW-1:0];
         py_ff <= req_tdata[2*CW-1:CW];
      end
      if (rdy[ST_OFS]) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
      if (rdy[ST_MUL]) begin
         dxc_ff <= dxc_in;
         dys_ff <= dys_in;
         dxs_ff <= dxs_in;
         dyc_ff <= dyc_in;
      end
      if (rdy[ST_RND]) begin
         rnd_x_ff <= rnd_x_in;
         rnd_y_ff <= rnd_y_in;
      end
      if (rdy[ST_OUT]) begin
         rot_x_ff <= rot_x_in;
         rot_y_ff <= rot_y_in;
      end
   end

   assign rsp_tvalid = vld_ff[ST_OUT];
   assign rsp_tdata  = DATA_W'({rot_y_ff, rot_x_ff});

   // A transaction taken in with none delivered adds exactly one to the fill
   `PRAC_ASSERT_NEXT(a_fill_count, clock, reset,
      (req_tvalid && req_tready && !(rsp_tvalid && rsp_tready)),
      ($countones(vld_ff) == $past($countones(vld_ff)) + 1),
      "pipeline fill does not match accepted transaction")

   // Input is never refused while some stage is empty
   `PRAC_ASSERT_SAME(a_no_false_stall, clock, reset,
      (vld_ff != {NSTG{1'b1}}),
      (req_tready),
      "input stalled with an empty stage")

   // One of cosine and sine is always at least one half in magnitude
   `PRAC_ASSERT_SAME(a_trig_mag, clock, reset,
      (1'b1),
      (cos_v >= TRIG_HALF || cos_v <= -TRIG_HALF ||
       sin_v >= TRIG_HALF || sin_v <= -TRIG_HALF),
      "coefficient pair too small")

endmodule

@@ sv/prac_trig.sv @@
// Angle to cosine/sine unit: reduces the angle register to one turn and looks
// up the quarter-wave table. Depends on prac_pkg.
module prac_trig
   import prac_pkg::*;
#(
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic signed [ANGLE_W-1:0]       angle_deg,
   output logic signed [TRIG_FRAC_BITS+1:0] sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0] cos_val
);

   localparam int T = TRIG_FRAC_BITS;
   localparam logic [63:0] ONE64 = 64'd1 << T;
   localparam logic signed [T+1:0] ONE = (T+2)'(ONE64);

   localparam logic [1:0] QUAD_I   = 2'd0;
   localparam logic [1:0] QUAD_II  = 2'd1;
   localparam logic [1:0] QUAD_III = 2'd2;
   localparam logic [1:0] QUAD_IV  = 2'd3;

   // Round a 30-fraction-bit sine to T fraction bits, capped at 1.0
   function automatic logic [T:0] sin_fix(input int unsigned k);
      logic [63:0] s;
      logic [63:0] r;
      s = sin_q30(k);
      r = (s + (64'd1 << (29 - T))) >> (30 - T);
      if (r > ONE64 || k == QUARTER) begin
         r = ONE64;
      end
      return r[T:0];
   endfunction

   logic [T:0]            sin_tbl [0:QUARTER];
   logic signed [10:0]    ang_ext;
   logic signed [10:0]    ang_red;
   logic [8:0]            deg;
   logic [1:0]            quad;
   logic [6:0]            rem;
   logic [6:0]            rem_c;
   logic signed [T+1:0]   tr;
   logic signed [T+1:0]   tc;
   logic signed [T+1:0]   sin_in;
   logic signed [T+1:0]   cos_in;
   logic signed [T+1:0]   sin_ff;
   logic signed [T+1:0]   cos_ff;

   // Build the quarter-wave table at elaboration
   for (genvar k = 0; k <= QUARTER; k++) begin : g_tbl
      localparam logic [T:0] SIN_K = sin_fix(k);
      assign sin_tbl[k] = SIN_K;
   end

   // Reduce the angle to 0..359
   always_comb begin
      ang_ext = 11'(angle_deg);
      if (ang_ext < 0) begin
         ang_red = ang_ext + 11'(FULL_TURN);
         if (ang_red < 0) begin
            ang_red = ang_red + 11'(FULL_TURN);
         end
      end else if (ang_ext >= 11'(FULL_TURN)) begin
         ang_red = ang_ext - 11'(FULL_TURN);
      end else begin
         ang_red = ang_ext;
      end
      deg = ang_red[8:0];
   end

   // Split into quadrant and offset within it
   always_comb begin
      priority if (deg < 9'(QUARTER)) begin
         quad = QUAD_I;
         rem  = 7'(deg);
      end else if (deg < 9'(2 * QUARTER)) begin
         quad = QUAD_II;
         rem  = 7'(deg - 9'(QUARTER));
      end else if (deg < 9'(3 * QUARTER)) begin
         quad = QUAD_III;
         rem  = 7'(deg - 9'(2 * QUARTER));
      end else begin
         quad = QUAD_IV;
         rem  = 7'(deg - 9'(3 * QUARTER));
      end
      rem_c = 7'(QUARTER) - rem;
   end

   // Look up both table entries and apply quadrant signs
   always_comb begin
      tr = signed'({1'b0, sin_tbl[rem]});
      tc = signed'({1'b0, sin_tbl[rem_c]});
      unique case (quad)
         QUAD_I: begin
            sin_in = tr;
            cos_in = tc;
         end
         QUAD_II: begin
            sin_in = tc;
            cos_in = -tr;
         end
         QUAD_III: begin
            sin_in = -tr;
            cos_in = -tc;
         end
         QUAD_IV: begin
            sin_in = -tc;
            cos_in = tr;
         end
      endcase
   end

   // Hold the coefficients in registers; reset matches a zero angle
   always_ff @(posedge clock) begin
      if (reset) begin
         sin_ff <= '0;
         cos_ff <= ONE;
      end else begin
         sin_ff <= sin_in;
         cos_ff <= cos_in;
      end
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule
